FILE: rtl/core/cpna_pkg.sv
// Package of the channel pedestal/noise accumulator: sizes, codes, structs.
// No dependencies; used by every other file of the block but cpna_ram.
package cpna_pkg;

  localparam int unsigned NUM_CHIPS           = 16;
  localparam int unsigned CHANNELS_PER_CHIP   = 32;
  localparam int unsigned CHANNELS_PER_HYBRID = 128;
  localparam int unsigned COUNT_BITS          = 24;

  localparam int unsigned STORE_DEPTH = NUM_CHIPS * CHANNELS_PER_CHIP;
  localparam int unsigned IDX_W       = $clog2(STORE_DEPTH);

  // input / output field widths
  localparam int unsigned CHIP_W   = 4;
  localparam int unsigned CHAN_W   = 5;
  localparam int unsigned SAMPLE_W = 10;
  localparam int unsigned SQVAL_W  = 2 * SAMPLE_W;
  localparam int unsigned MEAN_W   = 14;
  localparam int unsigned SIGMA_W  = 13;
  localparam int unsigned THR_W    = 10;
  localparam int unsigned HYB_W    = 2;
  localparam int unsigned THR_MAX  = 1023;

  // config
  localparam int unsigned LIMIT_W    = 16;
  localparam int unsigned MULT_W     = 3;
  localparam int unsigned EVENTS_W   = 16;
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 16;

  localparam logic [LIMIT_W-1:0] EVENT_LIMIT_RST = LIMIT_W'(500);
  localparam logic [MULT_W-1:0]  SIGMA_MULT_RST  = MULT_W'(2);
  localparam logic [THR_W-1:0]   LOCKED_THR_RST  = THR_W'(1023);

  // accumulator and arithmetic widths
  localparam int unsigned SUM_W    = COUNT_BITS + SAMPLE_W;
  localparam int unsigned SQ_W     = COUNT_BITS + SQVAL_W;
  localparam int unsigned ENTRY_W  = COUNT_BITS + SUM_W + SQ_W;
  localparam int unsigned PROD_W   = 2 * COUNT_BITS + SQVAL_W;
  localparam int unsigned RAD_W    = PROD_W + 8;
  localparam int unsigned ROOT_W   = RAD_W / 2;
  localparam int unsigned REM_W    = ROOT_W + 2;
  localparam int unsigned DIV_W    = COUNT_BITS + 14;
  localparam int unsigned ITER_W   = $clog2(ROOT_W + 1);
  localparam int unsigned THRSUM_W = MEAN_W + 3;

  localparam logic [COUNT_BITS-1:0] COUNT_MAX = {COUNT_BITS{1'b1}};

  // raw global channel (chip * channels + channel) over all input codes
  localparam int unsigned GLOBAL_MAX = (1 << CHIP_W) * CHANNELS_PER_CHIP + (1 << CHAN_W);
  localparam int unsigned GLOBAL_W   = $clog2(GLOBAL_MAX);
  localparam int unsigned HYB_STEPS  = GLOBAL_MAX / CHANNELS_PER_HYBRID;

  // command queue
  localparam int unsigned QUEUE_DEPTH = 4;
  localparam int unsigned QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int unsigned QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_EVENT_LIMIT = 2'd0,
    REG_SIGMA_MULT  = 2'd1,
    REG_LOCKED_THR  = 2'd2
  } cfg_reg_e;

  typedef enum logic [0:0] {
    OP_SAMPLE  = 1'b0,
    OP_READOUT = 1'b1
  } op_e;

  typedef struct packed {
    op_e                  op;
    logic                 chan_ok;
    logic                 chan_zero;
    logic [IDX_W-1:0]     idx;
    logic [SAMPLE_W-1:0]  sample;
    logic [SQVAL_W-1:0]   sq_val;
    logic [HYB_W-1:0]     hybrid;
  } cmd_t;

  typedef struct packed {
    logic               present;
    logic [MEAN_W-1:0]  mean_value;
    logic [SIGMA_W-1:0] sigma_value;
    logic [THR_W-1:0]   threshold;
    logic               emit_threshold;
    logic               locked;
    logic [HYB_W-1:0]   hybrid_index;
  } result_t;

  typedef struct packed {
    logic [MULT_W-1:0] sigma_mult;
    logic [THR_W-1:0]  locked_thr;
  } back_cfg_t;

  // board number: global / CHANNELS_PER_HYBRID, as a set of constant compares
  function automatic logic [HYB_W-1:0] hybrid_of(input logic [GLOBAL_W-1:0] global_ch);
    int unsigned cnt;
    cnt = 0;
    for (int unsigned k = 1; k <= HYB_STEPS; k++) begin
      if (32'(global_ch) >= k * CHANNELS_PER_HYBRID) cnt++;
    end
    return cnt[HYB_W-1:0];
  endfunction

endpackage

FILE: rtl/core/cpna_if.sv
// Valid/ready channel interfaces of the accumulator: input items and results.
// Depends on cpna_pkg.
interface cpna_in_if;
  import cpna_pkg::*;
  logic                valid;
  logic                ready;
  logic                kind;
  logic [CHIP_W-1:0]   chip_index;
  logic [CHAN_W-1:0]   chip_channel;
  logic [SAMPLE_W-1:0] sample_value;
  logic                header_word;
  logic                end_of_event;

  modport source (output valid, kind, chip_index, chip_channel, sample_value,
                  header_word, end_of_event, input ready);
  modport sink   (input valid, kind, chip_index, chip_channel, sample_value,
                  header_word, end_of_event, output ready);
endinterface

interface cpna_out_if;
  import cpna_pkg::*;
  logic               valid;
  logic               ready;
  logic               present;
  logic [MEAN_W-1:0]  mean_value;
  logic [SIGMA_W-1:0] sigma_value;
  logic [THR_W-1:0]   threshold;
  logic               emit_threshold;
  logic               locked;
  logic [HYB_W-1:0]   hybrid_index;

  modport source (output valid, present, mean_value, sigma_value, threshold,
                  emit_threshold, locked, hybrid_index, input ready);
  modport sink   (input valid, present, mean_value, sigma_value, threshold,
                  emit_threshold, locked, hybrid_index, output ready);
endinterface

FILE: rtl/core/channel_pedestal_noise_accumulator_unit.sv
// Top level of the per-channel pedestal/noise accumulator.
// Depends on cpna_pkg, cpna_if, cpna_front, cpna_fifo, cpna_back, cpna_ram.
//
// Per-channel pedestal and noise accumulator. Each of NUM_CHIPS x
// CHANNELS_PER_CHIP channels keeps count, sum and sum of squares in one
// 512-entry RAM. Sample transactions (kind 0) add into the addressed channel
// until event_limit events have been seen; a readout transaction (kind 1)
// returns mean and sigma in Q.4 and a zero-suppression threshold
// (mean + sigma_multiplier * sigma, integer part, saturated to 1023), or the
// locked threshold when the variance is exactly zero. After reset the store
// is swept to zero, one entry per cycle; no input transaction is taken during
// the sweep (config writes still go through). The front end accepts one
// transaction per cycle, while the queue is not full, into a 4-deep command
// queue; the back end works one command at a time through the store's
// read-modify-write port. A sample is read and written back; a readout of an
// absent channel goes straight to the result; others divide for the mean,
// run two shift-add multiplies and, for a nonzero variance, a square root
// and a second divide, all sharing one step counter. The result sits in an
// output register, so samples keep flowing while a result waits to be taken.
module channel_pedestal_noise_accumulator_unit (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  cpna_in_if.sink                         in_if,
  cpna_out_if.source                      out_if,
  input  logic                            cfg_we_i,
  input  logic [cpna_pkg::CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [cpna_pkg::CFG_DATA_W-1:0] cfg_wdata_i
);
  import cpna_pkg::*;

  // configuration registers
  logic [LIMIT_W-1:0] event_limit_q;
  logic [MULT_W-1:0]  sigma_mult_q;
  logic [THR_W-1:0]   locked_thr_q;

  // front -> queue -> back
  logic      push, pop, q_empty, q_full, clearing;
  cmd_t      front_cmd, head_cmd;
  back_cfg_t back_cfg;

  // writes to unused indexes are dropped
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      event_limit_q <= EVENT_LIMIT_RST;
      sigma_mult_q  <= SIGMA_MULT_RST;
      locked_thr_q  <= LOCKED_THR_RST;
    end else if (cfg_we_i) begin
      priority if (cfg_index_i == REG_EVENT_LIMIT) begin
        event_limit_q <= cfg_wdata_i[LIMIT_W-1:0];
      end else if (cfg_index_i == REG_SIGMA_MULT) begin
        sigma_mult_q <= cfg_wdata_i[MULT_W-1:0];
      end else if (cfg_index_i == REG_LOCKED_THR) begin
        locked_thr_q <= cfg_wdata_i[THR_W-1:0];
      end else begin
        event_limit_q <= event_limit_q;
      end
    end
  end

  assign back_cfg.sigma_mult = sigma_mult_q;
  assign back_cfg.locked_thr = locked_thr_q;

  // front end: event counting, channel decode, drop of ignored samples
  cpna_front u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_if         (in_if),
    .event_limit_i (event_limit_q),
    .clearing_i    (clearing),
    .full_i        (q_full),
    .push_o        (push),
    .cmd_o         (front_cmd)
  );

  // decouples the one-per-cycle input (unless stalled) from the multi-cycle back end
  cpna_fifo u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .cmd_i   (front_cmd),
    .pop_i   (pop),
    .cmd_o   (head_cmd),
    .empty_o (q_empty),
    .full_o  (q_full)
  );

  // back end: store, accumulate, readout arithmetic, output register
  cpna_back u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_i      (back_cfg),
    .empty_i    (q_empty),
    .cmd_i      (head_cmd),
    .pop_o      (pop),
    .clearing_o (clearing),
    .out_if     (out_if)
  );
endmodule

FILE: rtl/core/cpna_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies.
module cpna_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) mem[waddr_i] <= wdata_i;
    rdata_o <= mem[raddr_i];
  end
endmodule

FILE: rtl/core/cpna_front.sv
// Front end: takes input transactions, tracks events, classifies into commands.
// Depends on cpna_pkg and cpna_if.
module cpna_front (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  cpna_in_if.sink                           in_if,
  input  logic [cpna_pkg::LIMIT_W-1:0]      event_limit_i,
  input  logic                              clearing_i,
  input  logic                              full_i,
  output logic                              push_o,
  output cpna_pkg::cmd_t                    cmd_o
);
  import cpna_pkg::*;

  logic [EVENTS_W-1:0] events_seen_q, events_seen_d;
  logic                accept, chan_ok, limit_hit, is_readout;
  logic [GLOBAL_W-1:0] global_ch;

  assign in_if.ready = !full_i && !clearing_i;
  assign accept      = in_if.valid && in_if.ready;
  assign is_readout  = (in_if.kind == OP_READOUT);

  assign chan_ok   = (32'(in_if.chip_index) < NUM_CHIPS) &&
                     (32'(in_if.chip_channel) < CHANNELS_PER_CHIP);
  assign global_ch = GLOBAL_W'(in_if.chip_index) * GLOBAL_W'(CHANNELS_PER_CHIP) +
                     GLOBAL_W'(in_if.chip_channel);
  assign limit_hit = (events_seen_q >= event_limit_i);

  always_comb begin
    cmd_o.op        = is_readout ? OP_READOUT : OP_SAMPLE;
    cmd_o.chan_ok   = chan_ok;
    cmd_o.chan_zero = (in_if.chip_channel == '0);
    cmd_o.idx       = chan_ok ? global_ch[IDX_W-1:0] : '0;
    cmd_o.sample    = in_if.sample_value;
    cmd_o.sq_val    = SQVAL_W'(in_if.sample_value) * SQVAL_W'(in_if.sample_value);
    cmd_o.hybrid    = hybrid_of(global_ch);
  end

  // samples past the event limit vanish, header words only count events
  assign push_o = accept && (is_readout || (!limit_hit && !in_if.header_word && chan_ok));

  always_comb begin
    events_seen_d = events_seen_q;
    if (accept && !is_readout && !limit_hit && in_if.end_of_event) begin
      events_seen_d = events_seen_q + EVENTS_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      events_seen_q <= '0;
    end else begin
      events_seen_q <= events_seen_d;
    end
  end

  a_events_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (events_seen_q != $past(events_seen_q)) |->
      (events_seen_q == $past(events_seen_q) + EVENTS_W'(1)))
    else $error("event counter moved by more than one");
endmodule

FILE: rtl/core/cpna_fifo.sv
// Command queue between front and back end.
// Depends on cpna_pkg.
module cpna_fifo (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           push_i,
  input  cpna_pkg::cmd_t cmd_i,
  input  logic           pop_i,
  output cpna_pkg::cmd_t cmd_o,
  output logic           empty_o,
  output logic           full_o
);
  import cpna_pkg::*;

  cmd_t              mem_q [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [QCNT_W-1:0] count_q, count_d;

  assign empty_o = (count_q == '0);
  assign full_o  = (count_q == QCNT_W'(QUEUE_DEPTH));
  assign cmd_o   = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (push_i) begin
      wr_ptr_d = (wr_ptr_q == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + QPTR_W'(1);
    end
    if (pop_i) begin
      rd_ptr_d = (rd_ptr_q == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + QPTR_W'(1);
    end
    if (push_i && !pop_i) count_d = count_q + QCNT_W'(1);
    else if (pop_i && !push_i) count_d = count_q - QCNT_W'(1);
  end

  always_ff @(posedge clk_i) begin
    if (push_i) mem_q[wr_ptr_q] <= cmd_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  a_no_pop_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_i |-> !empty_o)
    else $error("pop from empty queue");
  a_no_push_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_i |-> (!full_o || pop_i))
    else $error("push into full queue");
endmodule

FILE: rtl/core/cpna_back.sv
// Back end: store clear pass, sample accumulation and readout arithmetic.
// Depends on cpna_pkg, cpna_if and cpna_ram.
module cpna_back (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  cpna_pkg::back_cfg_t cfg_i,
  input  logic                empty_i,
  input  cpna_pkg::cmd_t      cmd_i,
  output logic                pop_o,
  output logic                clearing_o,
  cpna_out_if.source          out_if
);
  import cpna_pkg::*;

  typedef enum logic [10:0] {
    ST_CLEAR    = 11'b000_0000_0001,
    ST_IDLE     = 11'b000_0000_0010,
    ST_FETCH    = 11'b000_0000_0100,
    ST_DIV_MEAN = 11'b000_0000_1000,
    ST_MUL_A    = 11'b000_0001_0000,
    ST_MUL_B    = 11'b000_0010_0000,
    ST_DIFF     = 11'b000_0100_0000,
    ST_SQRT     = 11'b000_1000_0000,
    ST_DIV_SIG  = 11'b001_0000_0000,
    ST_THRESH   = 11'b010_0000_0000,
    ST_RESULT   = 11'b100_0000_0000
  } state_e;

  state_e state_q, state_d;

  logic [IDX_W-1:0]      clr_addr_q, clr_addr_d;
  cmd_t                  cmd_q, cmd_d;
  logic [COUNT_BITS-1:0] n_q, n_d;
  logic [SUM_W-1:0]      s_q, s_d;
  logic [SQ_W-1:0]       sq_q, sq_d;
  logic [SUM_W-1:0]      mul_a_q, mul_a_d;
  logic [PROD_W-1:0]     mul_b_q, mul_b_d, acc_q, acc_d, prod_a_q, prod_a_d;
  logic [ITER_W-1:0]     iter_q, iter_d;
  logic [RAD_W-1:0]      rad_q, rad_d;
  logic [REM_W-1:0]      rem_q, rem_d;
  logic [ROOT_W-1:0]     root_q, root_d;
  logic [DIV_W-1:0]      div_r_q, div_r_d, dvs_q, dvs_d;
  logic [MEAN_W-1:0]     quot_q, quot_d;
  logic [MEAN_W-1:0]     mean_q, mean_d;
  logic [SIGMA_W-1:0]    sigma_q, sigma_d;
  result_t               res_q, res_d, out_q, out_d;
  logic                  out_valid_q, out_valid_d;

  // memory port
  logic               ram_we;
  logic [IDX_W-1:0]   ram_waddr;
  logic [ENTRY_W-1:0] ram_wdata, ram_rdata;

  // unpacked entry
  logic [COUNT_BITS-1:0] e_cnt, e_n;
  logic [SUM_W-1:0]      e_sum;
  logic [SQ_W-1:0]       e_sq;

  // shared step logic
  logic [PROD_W-1:0]   acc_next;
  logic                div_ge;
  logic [DIV_W-1:0]    div_r_next;
  logic [MEAN_W-1:0]   quot_next;
  logic [REM_W-1:0]    rem_sh, rem_trial;
  logic                sq_ge;
  logic [PROD_W-1:0]   diff;
  logic [THRSUM_W-1:0] thr_sum;
  logic [SIGMA_W-1:0]  thr_sh;

  cpna_ram #(.WIDTH(ENTRY_W), .DEPTH(STORE_DEPTH)) u_store (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .raddr_i (cmd_i.idx),
    .rdata_o (ram_rdata)
  );

  assign e_cnt = ram_rdata[ENTRY_W-1 -: COUNT_BITS];
  assign e_sum = ram_rdata[SUM_W+SQ_W-1 -: SUM_W];
  assign e_sq  = ram_rdata[SQ_W-1:0];
  assign e_n   = cmd_q.chan_ok ? e_cnt : '0;

  // one bit of shift-add multiply per cycle
  assign acc_next = acc_q + (mul_a_q[0] ? mul_b_q : '0);

  // restoring divide, one quotient bit per cycle
  assign div_ge     = (div_r_q >= dvs_q);
  assign div_r_next = div_ge ? div_r_q - dvs_q : div_r_q;
  assign quot_next  = {quot_q[MEAN_W-2:0], div_ge};

  // digit-by-digit square root, one root bit per cycle
  assign rem_sh    = {rem_q[REM_W-3:0], rad_q[RAD_W-1 -: 2]};
  assign rem_trial = {root_q, 2'b01};
  assign sq_ge     = (rem_sh >= rem_trial);

  // n*sumsq - sum^2, clamped at zero
  assign diff = (prod_a_q >= acc_q) ? prod_a_q - acc_q : '0;

  assign thr_sum = THRSUM_W'(mean_q) +
                   THRSUM_W'(16'(cfg_i.sigma_mult) * 16'(sigma_q));
  assign thr_sh  = thr_sum[THRSUM_W-1:4];

  always_comb begin
    state_d     = state_q;
    clr_addr_d  = clr_addr_q;
    cmd_d       = cmd_q;
    n_d         = n_q;
    s_d         = s_q;
    sq_d        = sq_q;
    mul_a_d     = mul_a_q;
    mul_b_d     = mul_b_q;
    acc_d       = acc_q;
    prod_a_d    = prod_a_q;
    iter_d      = iter_q;
    rad_d       = rad_q;
    rem_d       = rem_q;
    root_d      = root_q;
    div_r_d     = div_r_q;
    dvs_d       = dvs_q;
    quot_d      = quot_q;
    mean_d      = mean_q;
    sigma_d     = sigma_q;
    res_d       = res_q;
    out_d       = out_q;
    out_valid_d = out_valid_q && !out_if.ready;
    pop_o       = 1'b0;
    ram_we      = 1'b0;
    ram_waddr   = cmd_q.idx;
    ram_wdata   = {e_cnt + COUNT_BITS'(1), e_sum + SUM_W'(cmd_q.sample),
                   e_sq + SQ_W'(cmd_q.sq_val)};

    unique case (state_q)
      ST_CLEAR: begin
        ram_we     = 1'b1;
        ram_waddr  = clr_addr_q;
        ram_wdata  = '0;
        clr_addr_d = clr_addr_q + IDX_W'(1);
        if (clr_addr_q == IDX_W'(STORE_DEPTH - 1)) state_d = ST_IDLE;
      end
      ST_IDLE: begin
        if (!empty_i) begin
          pop_o   = 1'b1;
          cmd_d   = cmd_i;
          state_d = ST_FETCH;
        end
      end
      ST_FETCH: begin
        if (cmd_q.op == OP_SAMPLE) begin
          ram_we  = (e_cnt != COUNT_MAX);
          state_d = ST_IDLE;
        end else begin
          n_d  = e_n;
          s_d  = e_sum;
          sq_d = e_sq;
          res_d              = '0;
          res_d.hybrid_index = cmd_q.hybrid;
          if (e_n == '0) begin
            state_d = ST_RESULT;
          end else begin
            div_r_d = DIV_W'({e_sum, 4'b0000});
            dvs_d   = DIV_W'(e_n) << (MEAN_W - 1);
            quot_d  = '0;
            iter_d  = '0;
            state_d = ST_DIV_MEAN;
          end
        end
      end
      ST_DIV_MEAN: begin
        div_r_d = div_r_next;
        dvs_d   = dvs_q >> 1;
        quot_d  = quot_next;
        iter_d  = iter_q + ITER_W'(1);
        if (iter_q == ITER_W'(MEAN_W - 1)) begin
          mean_d  = quot_next;
          mul_a_d = SUM_W'(n_q);
          mul_b_d = PROD_W'(sq_q);
          acc_d   = '0;
          iter_d  = '0;
          state_d = ST_MUL_A;
        end
      end
      ST_MUL_A: begin
        acc_d   = acc_next;
        mul_a_d = mul_a_q >> 1;
        mul_b_d = mul_b_q << 1;
        iter_d  = iter_q + ITER_W'(1);
        if (iter_q == ITER_W'(SUM_W - 1)) begin
          prod_a_d = acc_next;
          mul_a_d  = s_q;
          mul_b_d  = PROD_W'(s_q);
          acc_d    = '0;
          iter_d   = '0;
          state_d  = ST_MUL_B;
        end
      end
      ST_MUL_B: begin
        acc_d   = acc_next;
        mul_a_d = mul_a_q >> 1;
        mul_b_d = mul_b_q << 1;
        iter_d  = iter_q + ITER_W'(1);
        if (iter_q == ITER_W'(SUM_W - 1)) state_d = ST_DIFF;
      end
      ST_DIFF: begin
        res_d.present    = 1'b1;
        res_d.mean_value = mean_q;
        if (diff == '0) begin
          res_d.locked         = 1'b1;
          res_d.threshold      = cfg_i.locked_thr;
          res_d.emit_threshold = cmd_q.chan_zero;
          state_d              = ST_RESULT;
        end else begin
          rad_d   = {diff, 8'h00};
          rem_d   = '0;
          root_d  = '0;
          iter_d  = '0;
          state_d = ST_SQRT;
        end
      end
      ST_SQRT: begin
        rad_d  = rad_q << 2;
        rem_d  = sq_ge ? rem_sh - rem_trial : rem_sh;
        root_d = {root_q[ROOT_W-2:0], sq_ge};
        iter_d = iter_q + ITER_W'(1);
        if (iter_q == ITER_W'(ROOT_W - 1)) begin
          div_r_d = DIV_W'({root_q[ROOT_W-2:0], sq_ge});
          dvs_d   = DIV_W'(n_q) << (MEAN_W - 1);
          quot_d  = '0;
          iter_d  = '0;
          state_d = ST_DIV_SIG;
        end
      end
      ST_DIV_SIG: begin
        div_r_d = div_r_next;
        dvs_d   = dvs_q >> 1;
        quot_d  = quot_next;
        iter_d  = iter_q + ITER_W'(1);
        if (iter_q == ITER_W'(MEAN_W - 1)) begin
          sigma_d = quot_next[SIGMA_W-1:0];
          state_d = ST_THRESH;
        end
      end
      ST_THRESH: begin
        res_d.sigma_value    = sigma_q;
        res_d.emit_threshold = 1'b1;
        res_d.threshold      = (32'(thr_sh) > THR_MAX) ? THR_W'(THR_MAX)
                                                       : thr_sh[THR_W-1:0];
        state_d              = ST_RESULT;
      end
      ST_RESULT: begin
        if (!out_valid_d) begin
          out_d       = res_q;
          out_valid_d = 1'b1;
          state_d     = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_CLEAR;
      clr_addr_q  <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      clr_addr_q  <= clr_addr_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cmd_q    <= cmd_d;
    n_q      <= n_d;
    s_q      <= s_d;
    sq_q     <= sq_d;
    mul_a_q  <= mul_a_d;
    mul_b_q  <= mul_b_d;
    acc_q    <= acc_d;
    prod_a_q <= prod_a_d;
    iter_q   <= iter_d;
    rad_q    <= rad_d;
    rem_q    <= rem_d;
    root_q   <= root_d;
    div_r_q  <= div_r_d;
    dvs_q    <= dvs_d;
    quot_q   <= quot_d;
    mean_q   <= mean_d;
    sigma_q  <= sigma_d;
    res_q    <= res_d;
    out_q    <= out_d;
  end

  assign clearing_o            = (state_q == ST_CLEAR);
  assign out_if.valid          = out_valid_q;
  assign out_if.present        = out_q.present;
  assign out_if.mean_value     = out_q.mean_value;
  assign out_if.sigma_value    = out_q.sigma_value;
  assign out_if.threshold      = out_q.threshold;
  assign out_if.emit_threshold = out_q.emit_threshold;
  assign out_if.locked         = out_q.locked;
  assign out_if.hybrid_index   = out_q.hybrid_index;

  a_no_pop_in_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_CLEAR) |-> (!pop_o && !out_valid_q))
    else $error("command taken during store clear");
endmodule
